// ----- hdl/assert_macros.svh -----
// Assertion macros for the checker file of the mixer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held.
`define FWADM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also runs through reset.
`define FWADM_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/fwadm_pkg.sv -----
// Shared types, constants and coefficient lookups for the X-drive mixer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fwadm_pkg;

  localparam int ANGLE_BITS = 16;
  localparam int LEVEL_BITS = 8;
  localparam int WHEEL_CNT  = 4;

  // quarter-wave table: one entry per fraction step, both ends included
  localparam int FRAC_BITS = ANGLE_BITS - 2;
  localparam int TBL_DEPTH = (1 << FRAC_BITS) + 1;
  localparam int TBL_AW    = FRAC_BITS + 1;
  localparam int SINE_W    = 16;
  localparam logic [TBL_AW-1:0] TBL_LAST = TBL_AW'(1 << FRAC_BITS);
  localparam logic [TBL_AW-1:0] TBL_HALF = TBL_AW'(1 << (FRAC_BITS - 1));

  // polynomial datapath (Q30)
  localparam int MUL_W = 32;
  localparam int TH_W  = 30;
  localparam int ACC_W = 31;
  localparam int DIV_W = 6;
  localparam logic [MUL_W-1:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [ACC_W-1:0] ONE_Q30     = 31'h4000_0000;

  // floor(2^32 / d) for the Horner divisors
  localparam logic [MUL_W-1:0] RCP_42 = 32'(64'h1_0000_0000 / 64'd42);
  localparam logic [MUL_W-1:0] RCP_20 = 32'(64'h1_0000_0000 / 64'd20);
  localparam logic [MUL_W-1:0] RCP_6  = 32'(64'h1_0000_0000 / 64'd6);
  localparam logic [MUL_W-1:0] RCP_56 = 32'(64'h1_0000_0000 / 64'd56);
  localparam logic [MUL_W-1:0] RCP_30 = 32'(64'h1_0000_0000 / 64'd30);
  localparam logic [MUL_W-1:0] RCP_12 = 32'(64'h1_0000_0000 / 64'd12);
  localparam logic [MUL_W-1:0] RCP_2  = 32'(64'h1_0000_0000 / 64'd2);

  // mixer product: |level| * |sine|, Q.15 result
  localparam int PROD_W    = LEVEL_BITS + 1 + SINE_W;
  localparam int Q15_SHIFT = 15;
  localparam int MAG_RAW_W = PROD_W - Q15_SHIFT;

  typedef struct packed {
    logic signed [LEVEL_BITS:0] drive_level;
    logic [ANGLE_BITS-1:0]      heading;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_BITS-1:0] mag_front_right;
    logic [LEVEL_BITS-1:0] mag_front_left;
    logic [LEVEL_BITS-1:0] mag_rear_left;
    logic [LEVEL_BITS-1:0] mag_rear_right;
    logic                  dir_front_right;
    logic                  dir_front_left;
    logic                  dir_rear_left;
    logic                  dir_rear_right;
  } mix_t;

  typedef struct packed {
    logic              en;
    logic [TBL_AW-1:0] addr;
    logic [SINE_W-1:0] data;
  } tbl_wr_t;

  typedef struct packed {
    logic [SINE_W-1:0] s;
    logic [SINE_W-1:0] c;
  } sc_t;

  // Horner divisor for a chain step; sine chain 42/20/6, cosine chain 56/30/12/2
  function automatic logic [DIV_W-1:0] step_div(input logic is_cos, input logic [1:0] step);
    logic [DIV_W-1:0] d;
    case ({is_cos, step})
      3'b000:  d = 6'd42;
      3'b001:  d = 6'd20;
      3'b010:  d = 6'd6;
      3'b100:  d = 6'd56;
      3'b101:  d = 6'd30;
      3'b110:  d = 6'd12;
      3'b111:  d = 6'd2;
      default: d = 6'd42;
    endcase
    return d;
  endfunction

  function automatic logic [MUL_W-1:0] step_rcp(input logic is_cos, input logic [1:0] step);
    logic [MUL_W-1:0] r;
    case ({is_cos, step})
      3'b000:  r = RCP_42;
      3'b001:  r = RCP_20;
      3'b010:  r = RCP_6;
      3'b100:  r = RCP_56;
      3'b101:  r = RCP_30;
      3'b110:  r = RCP_12;
      3'b111:  r = RCP_2;
      default: r = RCP_42;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/fwadm_qsine_gen.sv -----
// Quarter-wave sine generator: fills the wave table once after reset.
// One shared 32x32 multiplier, Horner evaluation in Q30. Uses fwadm_pkg.
`timescale 1ns / 1ps

module fwadm_qsine_gen import fwadm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  output tbl_wr_t wr_o,
  output logic    done_o
);

  localparam logic [3:0] GS_TH   = 4'd0;
  localparam logic [3:0] GS_SQ   = 4'd1;
  localparam logic [3:0] GS_T2   = 4'd2;
  localparam logic [3:0] GS_RM   = 4'd3;
  localparam logic [3:0] GS_QD   = 4'd4;
  localparam logic [3:0] GS_CORR = 4'd5;
  localparam logic [3:0] GS_X    = 4'd6;
  localparam logic [3:0] GS_V    = 4'd7;
  localparam logic [3:0] GS_WR   = 4'd8;
  localparam logic [3:0] GS_DONE = 4'd9;

  localparam logic [1:0] LAST_SIN_STEP = 2'd2;
  localparam logic [1:0] LAST_COS_STEP = 2'd3;
  localparam logic [31:0] RND_HALF     = 32'(1 << 14);
  localparam logic [16:0] Q15_ONE      = 17'(1 << 15);

  logic [3:0]        state_q, state_d;
  logic [TBL_AW-1:0] k_q, k_d;
  logic [1:0]        step_q, step_d;
  logic [TH_W-1:0]   th_q, th_d;
  logic [TH_W-1:0]   t2_q, t2_d;
  logic [TH_W-1:0]   x_q, x_d;
  logic [TH_W-1:0]   q0_q, q0_d;
  logic [ACC_W-1:0]  v_q, v_d;
  logic [63:0]       prod_q, prod_d;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              is_cos;
  logic [TBL_AW-1:0] m_arg;
  logic [DIV_W-1:0]  div;
  logic [TH_W-1:0]   rem, quo;
  logic [ACC_W-1:0]  acc;
  logic [1:0]        last_step;
  logic [31:0]       rnd;
  logic [16:0]       r17;

  // beyond the half point the entry comes from the cosine series at the mirror
  assign is_cos    = k_q > TBL_HALF;
  assign m_arg     = is_cos ? (TBL_LAST - k_q) : k_q;
  assign div       = step_div(is_cos, step_q);
  assign last_step = is_cos ? LAST_COS_STEP : LAST_SIN_STEP;

  // reciprocal quotient is low by at most one: one compare fixes it
  assign rem = x_q - prod_q[TH_W-1:0];
  assign quo = q0_q + TH_W'(rem >= TH_W'(div));
  assign acc = ONE_Q30 - {1'b0, quo};

  assign rnd = {1'b0, v_q} + RND_HALF;
  assign r17 = rnd[31:15];

  assign prod_d = {32'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    step_d  = step_q;
    th_d    = th_q;
    t2_d    = t2_q;
    x_d     = x_q;
    q0_d    = q0_q;
    v_d     = v_q;
    mul_a   = '0;
    mul_b   = '0;
    wr_o    = '0;
    case (state_q)
      GS_TH: begin
        mul_a   = MUL_W'(m_arg);
        mul_b   = HALF_PI_Q30;
        state_d = GS_SQ;
      end
      GS_SQ: begin
        th_d    = prod_q[FRAC_BITS +: TH_W];
        mul_a   = MUL_W'(th_d);
        mul_b   = MUL_W'(th_d);
        state_d = GS_T2;
      end
      GS_T2: begin
        t2_d    = prod_q[30 +: TH_W];
        x_d     = prod_q[30 +: TH_W];
        step_d  = '0;
        state_d = GS_RM;
      end
      GS_RM: begin
        mul_a   = MUL_W'(x_q);
        mul_b   = step_rcp(is_cos, step_q);
        state_d = GS_QD;
      end
      GS_QD: begin
        q0_d    = prod_q[32 +: TH_W];
        mul_a   = MUL_W'(q0_d);
        mul_b   = MUL_W'(div);
        state_d = GS_CORR;
      end
      GS_CORR: begin
        if (step_q == last_step) begin
          if (is_cos) begin
            v_d     = acc;
            state_d = GS_WR;
          end else begin
            mul_a   = MUL_W'(th_q);
            mul_b   = MUL_W'(acc);
            state_d = GS_V;
          end
        end else begin
          mul_a   = MUL_W'(t2_q);
          mul_b   = MUL_W'(acc);
          step_d  = step_q + 2'd1;
          state_d = GS_X;
        end
      end
      GS_X: begin
        x_d     = prod_q[30 +: TH_W];
        state_d = GS_RM;
      end
      GS_V: begin
        v_d     = prod_q[30 +: ACC_W];
        state_d = GS_WR;
      end
      GS_WR: begin
        wr_o.en   = 1'b1;
        wr_o.addr = k_q;
        wr_o.data = (r17 > Q15_ONE) ? Q15_ONE[SINE_W-1:0] : r17[SINE_W-1:0];
        if (k_q == TBL_LAST) begin
          state_d = GS_DONE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = GS_TH;
        end
      end
      GS_DONE: begin
        state_d = GS_DONE;
      end
      default: begin
        state_d = GS_TH;
      end
    endcase
  end

  assign done_o = (state_q == GS_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_TH;
      k_q     <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    th_q   <= th_d;
    t2_q   <= t2_d;
    x_q    <= x_d;
    q0_q   <= q0_d;
    v_q    <= v_d;
    prod_q <= prod_d;
  end

endmodule

// ----- hdl/fwadm_wave_table.sv -----
// Quarter-wave sine memory: one fill port, two registered read ports.
// Reads the fraction and its mirror in the same cycle. Uses fwadm_pkg.
`timescale 1ns / 1ps

module fwadm_wave_table import fwadm_pkg::*; (
  input  logic                 clk_i,
  input  tbl_wr_t              wr_i,
  input  logic                 rd_en_i,
  input  logic [FRAC_BITS-1:0] frac_i,
  output sc_t                  sc_o
);

  logic [SINE_W-1:0] mem_q [TBL_DEPTH];
  logic [TBL_AW-1:0] addr_s, addr_c;
  sc_t               sc_q;

  assign addr_s = {1'b0, frac_i};
  assign addr_c = TBL_LAST - addr_s;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sc_q.s <= mem_q[addr_s];
      sc_q.c <= mem_q[addr_c];
    end
  end

  assign sc_o = sc_q;

endmodule

// ----- hdl/fwadm_wheel_mix.sv -----
// Wheel mixing stages: quadrant fold, level products, saturation and direction.
// Product register then output register, both held on stall. Uses fwadm_pkg.
`timescale 1ns / 1ps

module fwadm_wheel_mix import fwadm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   adv_i,
  input  logic signed [LEVEL_BITS:0] level_i,
  input  logic [1:0]             quad_i,
  input  sc_t                    sc_i,
  input  logic [WHEEL_CNT-1:0]   rev_i,
  output mix_t                   mix_o
);

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  localparam int WHEEL_FR = 0;
  localparam int WHEEL_FL = 1;
  localparam int WHEEL_RL = 2;
  localparam int WHEEL_RR = 3;

  localparam logic [MAG_RAW_W-1:0] MAG_MAX = MAG_RAW_W'((1 << LEVEL_BITS) - 1);

  logic [LEVEL_BITS:0] lvl_u, lvl_abs;
  logic                lvl_neg;
  logic [SINE_W-1:0]   smag, cmag;
  logic                sneg, cneg;
  logic [PROD_W-1:0]   ps_d, pc_d;
  logic [PROD_W-1:0]   ps_q, pc_q;
  logic                ns_q, nc_q;
  logic                nz_s, nz_c;
  logic [LEVEL_BITS-1:0] sat_s, sat_c;
  mix_t                mix_d, mix_q;

  function automatic logic [LEVEL_BITS-1:0] sat_mag(input logic [PROD_W-1:0] pr);
    logic [MAG_RAW_W-1:0] m;
    m = pr[PROD_W-1:Q15_SHIFT];
    return (m > MAG_MAX) ? MAG_MAX[LEVEL_BITS-1:0] : m[LEVEL_BITS-1:0];
  endfunction

  assign lvl_u   = level_i;
  assign lvl_neg = level_i[LEVEL_BITS];
  assign lvl_abs = lvl_neg ? (~lvl_u + 1'b1) : lvl_u;

  // (S, C) per quadrant: (s, c), (c, -s), (-s, -c), (-c, s)
  always_comb begin
    case (quad_i)
      QUAD_I: begin
        smag = sc_i.s; sneg = 1'b0;
        cmag = sc_i.c; cneg = 1'b0;
      end
      QUAD_II: begin
        smag = sc_i.c; sneg = 1'b0;
        cmag = sc_i.s; cneg = 1'b1;
      end
      QUAD_III: begin
        smag = sc_i.s; sneg = 1'b1;
        cmag = sc_i.c; cneg = 1'b1;
      end
      QUAD_IV: begin
        smag = sc_i.c; sneg = 1'b1;
        cmag = sc_i.s; cneg = 1'b0;
      end
      default: begin
        smag = sc_i.s; sneg = 1'b0;
        cmag = sc_i.c; cneg = 1'b0;
      end
    endcase
  end

  assign ps_d = PROD_W'(lvl_abs) * PROD_W'(smag);
  assign pc_d = PROD_W'(lvl_abs) * PROD_W'(cmag);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ps_q <= ps_d;
      pc_q <= pc_d;
      ns_q <= lvl_neg ^ sneg;
      nc_q <= lvl_neg ^ cneg;
    end
  end

  assign nz_s  = |ps_q[PROD_W-1:Q15_SHIFT];
  assign nz_c  = |pc_q[PROD_W-1:Q15_SHIFT];
  assign sat_s = sat_mag(ps_q);
  assign sat_c = sat_mag(pc_q);

  // wheels 1 and 2 take the negated product
  always_comb begin
    mix_d.mag_front_right = sat_s;
    mix_d.mag_front_left  = sat_c;
    mix_d.mag_rear_left   = sat_s;
    mix_d.mag_rear_right  = sat_c;
    mix_d.dir_front_right = nz_s && (ns_q == rev_i[WHEEL_FR]);
    mix_d.dir_front_left  = nz_c && (!nc_q == rev_i[WHEEL_FL]);
    mix_d.dir_rear_left   = nz_s && (!ns_q == rev_i[WHEEL_RL]);
    mix_d.dir_rear_right  = nz_c && (nc_q == rev_i[WHEEL_RR]);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mix_q <= mix_d;
    end
  end

  assign mix_o = mix_q;

endmodule

// ----- hdl/four_wheel_angle_drive_mixer.sv -----
// Top level of the X-drive mixer: handshakes, config register, pipeline valids.
// Instantiates fwadm_qsine_gen, fwadm_wave_table and fwadm_wheel_mix; uses fwadm_pkg.
`timescale 1ns / 1ps
//
// Channel  Handshake                    Payload
// -------  ---------------------------  -------------------------------------------
// in       in_valid_i / in_stall_o      cmd_t: drive_level, heading
// out      out_valid_o / out_stall_i    mix_t: four magnitudes, four direction bits
// cfg      cfg_valid_i / cfg_ready_o    cfg_data_i: reverse mask, one bit per wheel
//
// One transaction per cycle once the wave table is filled, unless the output stalls;
//   results pass the table read, product register and output register in turn.
// The rate is set by the table's two read ports, which serve sine and cosine together.
// After reset the generator fills the table through its single shared multiplier;
//   in_stall_o stays high until the fill is done.
// A stalled output freezes the whole pipeline; in_stall_o then goes high in the
//   same cycle, so a held result never blocks intake while the output is free.
// Config writes are always taken (cfg_ready_o tied high) and apply at the output stage.

module four_wheel_angle_drive_mixer import fwadm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  cmd_t                 in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mix_t                 out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [WHEEL_CNT-1:0] cfg_data_i
);

  logic [WHEEL_CNT-1:0]       rev_q;
  logic                       fill_done;
  tbl_wr_t                    tbl_wr;
  sc_t                        tbl_rd;

  // pipeline control
  logic                       adv;
  logic                       accept;
  logic                       v1_q, v2_q, out_valid_q;

  // stage 1 payload, aligned with the table read
  logic signed [LEVEL_BITS:0] lvl1_q;
  logic [1:0]                 quad1_q;

  // everything moves unless a result sits unclaimed at the output
  assign adv         = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !fill_done || !adv;
  assign accept      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rev_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lvl1_q  <= in_data_i.drive_level;
      quad1_q <= in_data_i.heading[ANGLE_BITS-1 -: 2];
    end
  end

  fwadm_qsine_gen u_qsine_gen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_o   (tbl_wr),
    .done_o (fill_done)
  );

  // low heading bits address the table; the mirror read gives the cosine
  fwadm_wave_table u_wave_table (
    .clk_i   (clk_i),
    .wr_i    (tbl_wr),
    .rd_en_i (adv),
    .frac_i  (in_data_i.heading[FRAC_BITS-1:0]),
    .sc_o    (tbl_rd)
  );

  fwadm_wheel_mix u_wheel_mix (
    .clk_i   (clk_i),
    .adv_i   (adv),
    .level_i (lvl1_q),
    .quad_i  (quad1_q),
    .sc_i    (tbl_rd),
    .rev_i   (rev_q),
    .mix_o   (out_data_o)
  );

  assign out_valid_o = out_valid_q;

endmodule

// ----- hdl/fwadm_checker.sv -----
// Port-level checks for the X-drive mixer, bound to the top level.
// Uses assert_macros.svh and fwadm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fwadm_checker import fwadm_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_stall_o,
  input logic out_valid_o,
  input logic out_stall_i,
  input mix_t out_data_o
);

  `FWADM_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result changed")

  `FWADM_ASSERT_RST(a_fill_stall, !rst_ni |=> in_stall_o, "intake open before table fill")

  `FWADM_ASSERT(a_drain_open, out_valid_o && !out_stall_i |-> !in_stall_o, "intake stalled while output drains")

  `FWADM_ASSERT(a_mag_pairs, out_valid_o |-> (out_data_o.mag_front_right == out_data_o.mag_rear_left) && (out_data_o.mag_front_left == out_data_o.mag_rear_right), "opposite wheel magnitudes differ")

  `FWADM_ASSERT(a_zero_dir, out_valid_o |-> (out_data_o.mag_front_right != '0 || !out_data_o.dir_front_right) && (out_data_o.mag_front_left != '0 || !out_data_o.dir_front_left) && (out_data_o.mag_rear_left != '0 || !out_data_o.dir_rear_left) && (out_data_o.mag_rear_right != '0 || !out_data_o.dir_rear_right), "direction set on idle wheel")

endmodule

bind four_wheel_angle_drive_mixer fwadm_checker u_fwadm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
